FILE: src/siph_pkg.sv
`default_nettype none

package siph_pkg;

   localparam logic [63:0] SEED_VALUE    = 64'd5381;
   localparam logic [31:0] MIX_MULT      = 32'd2654435761;
   localparam logic [63:0] OUT_MASK      = 64'h0000_0000_A5A5_A5A5;
   localparam logic [15:0] ROUNDS_RESET  = 16'd10007;
   localparam int          ROT_LEFT      = 13;
   localparam int          ROT_RIGHT     = 19;
   localparam int          DIGITS        = 5;
   localparam logic [7:0]  ASCII_ZERO    = 8'h30;

   localparam logic [1:0]  OP_APPEND_PW   = 2'd0;
   localparam logic [1:0]  OP_APPEND_SALT = 2'd1;
   localparam logic [1:0]  OP_START       = 2'd2;

   localparam logic        CSR_ROUND_COUNT = 1'b0;

   typedef enum logic [1:0] {
      SRC_PW    = 2'd0,
      SRC_SALT  = 2'd1,
      SRC_DIGIT = 2'd2
   } src_type;

   typedef struct packed {
      logic       wr_pw;
      logic       wr_salt;
      logic       set_drop;
      logic       seed;
      logic       fetch;
      src_type    src;
      logic [2:0] digit_idx;
      logic       mix;
      logic [1:0] pos;
      logic       mult;
      logic       sum;
      logic       next_round;
      logic       finish;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] digit_count;
      logic       out_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: src/siph_req_if.sv
`default_nettype none

interface siph_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: src/siph_rsp_if.sv
`default_nettype none

interface siph_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] masked_word;
   logic [63:0] shifted_word;
   logic        overflow;

   modport source (output valid, output masked_word, output shifted_word,
                   output overflow, input ready);
   modport sink (input valid, input masked_word, input shifted_word,
                 input overflow, output ready);
endinterface

`default_nettype wire

FILE: src/siph_ctrl.sv
`default_nettype none

module siph_ctrl #(
   parameter int PASSWORD_DEPTH = 128,
   parameter int SALT_DEPTH     = 32,
   localparam int PW_LW = $clog2(PASSWORD_DEPTH + 1),
   localparam int PW_AW = (PASSWORD_DEPTH > 1) ? $clog2(PASSWORD_DEPTH) : 1,
   localparam int SA_LW = $clog2(SALT_DEPTH + 1),
   localparam int SA_AW = (SALT_DEPTH > 1) ? $clog2(SALT_DEPTH) : 1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  [1:0]                 req_opcode,
   input  wire  [15:0]                round_count,
   input  siph_pkg::dp_stat_type      stat,
   output siph_pkg::dp_cmd_type       cmd,
   output logic [PW_AW-1:0]           pw_addr,
   output logic [SA_AW-1:0]           salt_addr
);
   import siph_pkg::*;

   localparam logic [PW_LW-1:0] PW_FULL = PW_LW'(PASSWORD_DEPTH);
   localparam logic [SA_LW-1:0] SA_FULL = SA_LW'(SALT_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MIX,
      ST_MULT,
      ST_SUM,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [PW_LW-1:0] plen_ff, plen_in, pidx_ff, pidx_in;
   logic [SA_LW-1:0] slen_ff, slen_in, sidx_ff, sidx_in;
   logic [2:0]       didx_ff, didx_in;
   logic [1:0]       pos_ff, pos_in;
   logic [15:0]      round_ff, round_in;
   logic             last_round;

   assign last_round = ({1'b0, round_ff} + 17'd1) == {1'b0, round_count};

   always_comb begin
      state_in  = state_ff;
      plen_in   = plen_ff;
      pidx_in   = pidx_ff;
      slen_in   = slen_ff;
      sidx_in   = sidx_ff;
      didx_in   = didx_ff;
      pos_in    = pos_ff;
      round_in  = round_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_opcode)
                  OP_APPEND_PW: begin
                     if (plen_ff < PW_FULL) begin
                        cmd.wr_pw = 1'b1;
                        plen_in   = plen_ff + PW_LW'(1);
                     end else begin
                        cmd.set_drop = 1'b1;
                     end
                  end
                  OP_APPEND_SALT: begin
                     if (slen_ff < SA_FULL) begin
                        cmd.wr_salt = 1'b1;
                        slen_in     = slen_ff + SA_LW'(1);
                     end else begin
                        cmd.set_drop = 1'b1;
                     end
                  end
                  OP_START: begin
                     cmd.seed = 1'b1;
                     round_in = '0;
                     pidx_in  = '0;
                     sidx_in  = '0;
                     didx_in  = '0;
                     pos_in   = '0;
                     state_in = (round_count == 16'd0) ? ST_FINISH : ST_FETCH;
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            // walk password, then salt, then the round digits
            if (pidx_ff < plen_ff) begin
               cmd.fetch = 1'b1;
               cmd.src   = SRC_PW;
               pidx_in   = pidx_ff + PW_LW'(1);
               state_in  = ST_MIX;
            end else if (sidx_ff < slen_ff) begin
               cmd.fetch = 1'b1;
               cmd.src   = SRC_SALT;
               sidx_in   = sidx_ff + SA_LW'(1);
               state_in  = ST_MIX;
            end else if (didx_ff < stat.digit_count) begin
               cmd.fetch     = 1'b1;
               cmd.src       = SRC_DIGIT;
               cmd.digit_idx = didx_ff;
               didx_in       = didx_ff + 3'd1;
               state_in      = ST_MIX;
            end else begin
               cmd.next_round = 1'b1;
               round_in       = round_ff + 16'd1;
               pidx_in        = '0;
               sidx_in        = '0;
               didx_in        = '0;
               pos_in         = '0;
               if (last_round) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            cmd.pos  = pos_ff;
            pos_in   = pos_ff + 2'd1;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FINISH: begin
            // hold until the previous result has been taken
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               plen_in    = '0;
               slen_in    = '0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign pw_addr   = cmd.wr_pw   ? plen_ff[PW_AW-1:0] : pidx_ff[PW_AW-1:0];
   assign salt_addr = cmd.wr_salt ? slen_ff[SA_AW-1:0] : sidx_ff[SA_AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         plen_ff  <= '0;
         pidx_ff  <= '0;
         slen_ff  <= '0;
         sidx_ff  <= '0;
         didx_ff  <= '0;
         pos_ff   <= '0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         plen_ff  <= plen_in;
         pidx_ff  <= pidx_in;
         slen_ff  <= slen_in;
         sidx_ff  <= sidx_in;
         didx_ff  <= didx_in;
         pos_ff   <= pos_in;
         round_ff <= round_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/siph_dp.sv
`default_nettype none

module siph_dp #(
   parameter int PASSWORD_DEPTH = 128,
   parameter int SALT_DEPTH     = 32,
   localparam int PW_AW = (PASSWORD_DEPTH > 1) ? $clog2(PASSWORD_DEPTH) : 1,
   localparam int SA_AW = (SALT_DEPTH > 1) ? $clog2(SALT_DEPTH) : 1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  siph_pkg::dp_cmd_type       cmd,
   input  wire  [PW_AW-1:0]           pw_addr,
   input  wire  [SA_AW-1:0]           salt_addr,
   input  wire  [7:0]                 data_byte,
   output siph_pkg::dp_stat_type      stat,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [63:0]                masked_word,
   output logic [63:0]                shifted_word,
   output logic                       overflow
);
   import siph_pkg::*;

   logic [7:0]  pw_mem   [PASSWORD_DEPTH];
   logic [7:0]  salt_mem [SALT_DEPTH];
   logic [7:0]  pw_rd_ff, salt_rd_ff, digit_ff;
   src_type     src_ff;

   logic [3:0]  bcd_ff [DIGITS];
   logic [3:0]  bcd_in [DIGITS];
   logic [2:0]  digit_count;
   logic [2:0]  digit_sel;

   logic [63:0] hash_ff;
   logic [63:0] mix_ff, mix_in;
   logic [63:0] lo_prod_ff;
   logic [31:0] hi_prod_ff;
   logic [63:0] hi_full;
   logic [7:0]  cur_byte;
   logic [63:0] scaled;
   logic [2:0]  shift_amt;
   logic        drop_ff;
   logic        rsp_valid_ff;
   logic [63:0] masked_ff, shifted_ff;
   logic        overflow_ff;
   logic        carry;

   always_ff @(posedge clock) begin
      if (cmd.wr_pw) begin
         pw_mem[pw_addr] <= data_byte;
      end
      pw_rd_ff <= pw_mem[pw_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_salt) begin
         salt_mem[salt_addr] <= data_byte;
      end
      salt_rd_ff <= salt_mem[salt_addr];
   end

   // decimal round number, least significant digit first
   always_comb begin
      digit_count = 3'd1;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            digit_count = 3'(i + 1);
         end
      end
   end

   always_comb begin
      carry = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         bcd_in[i] = bcd_ff[i];
         if (carry) begin
            if (bcd_ff[i] == 4'd9) begin
               bcd_in[i] = 4'd0;
            end else begin
               bcd_in[i] = bcd_ff[i] + 4'd1;
               carry     = 1'b0;
            end
         end
      end
   end

   // most significant digit goes out first
   assign digit_sel = digit_count - 3'd1 - cmd.digit_idx;

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         src_ff   <= cmd.src;
         digit_ff <= ASCII_ZERO | {4'd0, bcd_ff[digit_sel]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.seed) begin
         for (int i = 0; i < DIGITS; i++) begin
            bcd_ff[i] <= 4'd0;
         end
      end else if (cmd.next_round) begin
         for (int i = 0; i < DIGITS; i++) begin
            bcd_ff[i] <= bcd_in[i];
         end
      end
   end

   always_comb begin
      unique case (src_ff)
         SRC_PW:    cur_byte = pw_rd_ff;
         SRC_SALT:  cur_byte = salt_rd_ff;
         SRC_DIGIT: cur_byte = digit_ff;
         default:   cur_byte = digit_ff;
      endcase
   end

   assign scaled    = (hash_ff << 5) + hash_ff + {56'd0, cur_byte};
   assign shift_amt = {1'b0, cmd.pos} + 3'd1;
   assign mix_in    = scaled ^ (scaled >> shift_amt);
   assign hi_full   = {32'd0, mix_ff[63:32]} * {32'd0, MIX_MULT};

   always_ff @(posedge clock) begin
      if (cmd.mix) begin
         mix_ff <= mix_in;
      end
      if (cmd.mult) begin
         lo_prod_ff <= {32'd0, mix_ff[31:0]} * {32'd0, MIX_MULT};
         hi_prod_ff <= hi_full[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.seed) begin
         hash_ff <= SEED_VALUE;
      end else if (cmd.sum) begin
         hash_ff <= lo_prod_ff + {hi_prod_ff, 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         drop_ff <= 1'b0;
      end else if (cmd.set_drop) begin
         drop_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         masked_ff   <= hash_ff ^ OUT_MASK;
         shifted_ff  <= (hash_ff << ROT_LEFT) | (hash_ff >> ROT_RIGHT);
         overflow_ff <= drop_ff;
      end
   end

   assign stat.digit_count = digit_count;
   assign stat.out_busy    = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign masked_word      = masked_ff;
   assign shifted_word     = shifted_ff;
   assign overflow         = overflow_ff;

endmodule

`default_nettype wire

FILE: src/salted_iterated_password_hash.sv
// Append beats (password or salt byte) go in one per cycle while idle and may arrive
// back to back. A start beat closes the input while every round runs: each stored
// password byte, salt byte and decimal digit of the round number r is fetched, mixed,
// multiplied and added; the result is valid at the edge that reopens the input.
// A waiting result lets appends in but holds the next start's finish step until taken.
// Reset clears store lengths, drop flag and output valid, and sets round_count to 10007.
`default_nettype none

module salted_iterated_password_hash #(
   parameter int PASSWORD_DEPTH = 128,
   parameter int SALT_DEPTH     = 32
) (
   input  wire           clock,
   input  wire           reset,
   siph_req_if.sink      req_chan,
   siph_rsp_if.source    rsp_chan,
   input  wire           psel,
   input  wire           penable,
   input  wire           pwrite,
   input  wire  [2:0]    paddr,
   input  wire  [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);
   import siph_pkg::*;

   localparam int PW_AW = (PASSWORD_DEPTH > 1) ? $clog2(PASSWORD_DEPTH) : 1;
   localparam int SA_AW = (SALT_DEPTH > 1) ? $clog2(SALT_DEPTH) : 1;

   logic [15:0]      round_count_ff;
   logic             csr_write;
   dp_cmd_type       cmd;
   dp_stat_type      stat;
   logic [PW_AW-1:0] pw_addr;
   logic [SA_AW-1:0] salt_addr;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_ROUND_COUNT);
   assign prdata    = (paddr[2] == CSR_ROUND_COUNT) ? {16'd0, round_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= ROUNDS_RESET;
      end else if (csr_write) begin
         round_count_ff <= pwdata[15:0];
      end
   end

   siph_ctrl #(
      .PASSWORD_DEPTH (PASSWORD_DEPTH),
      .SALT_DEPTH     (SALT_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_opcode  (req_chan.opcode),
      .round_count (round_count_ff),
      .stat        (stat),
      .cmd         (cmd),
      .pw_addr     (pw_addr),
      .salt_addr   (salt_addr)
   );

   siph_dp #(
      .PASSWORD_DEPTH (PASSWORD_DEPTH),
      .SALT_DEPTH     (SALT_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .pw_addr      (pw_addr),
      .salt_addr    (salt_addr),
      .data_byte    (req_chan.data_byte),
      .stat         (stat),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .masked_word  (rsp_chan.masked_word),
      .shifted_word (rsp_chan.shifted_word),
      .overflow     (rsp_chan.overflow)
   );

endmodule

`default_nettype wire

FILE: bench/key_stretch_checker.sv
module key_stretch_checker #(
   parameter int PASSWORD_DEPTH = 128,
   parameter int SALT_DEPTH     = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  wire [1:0]   req_opcode,
   input  wire [7:0]   req_data_byte,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire [63:0]  rsp_masked_word,
   input  wire [63:0]  rsp_shifted_word,
   input  wire         rsp_overflow,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire         pready,
   input  wire [2:0]   paddr,
   input  wire [31:0]  pwdata,
   output int          fail_count,
   output int          hashes_waiting,
   output int          hashes_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import siph_pkg::*;

   localparam logic [63:0] HASH_SEED        = 64'd5381;
   localparam logic [63:0] MIX_FACTOR       = 64'd2654435761;
   localparam logic [63:0] OUT_XOR          = 64'h0000_0000_A5A5_A5A5;
   localparam logic [15:0] ROUNDS_AT_RESET  = 16'd10007;
   localparam logic [7:0]  DIGIT_ZERO       = 8'h30;
   localparam logic [2:0]  ROUND_COUNT_ADDR = {CSR_ROUND_COUNT, 2'b00};

   typedef struct packed {
      logic [63:0] masked_word;
      logic [63:0] shifted_word;
      logic        overflow;
   } digest_type;

   logic [7:0]  pw_bytes [PASSWORD_DEPTH];
   logic [7:0]  salt_bytes [SALT_DEPTH];
   int          pw_len;
   int          salt_len;
   logic        dropped;
   logic [15:0] round_count;
   digest_type  digests_due [$];
   int          mismatches;
   int          checked;

   function automatic logic [63:0] absorb_byte(input logic [63:0] s, input logic [7:0] b,
                                               input logic [1:0] pos);
      logic [63:0] t;
      t = s * 64'd33 + {56'd0, b};
      t = t ^ (t >> ({1'b0, pos} + 3'd1));
      return t * MIX_FACTOR;
   endfunction

   // Full stretch over the current stores and round count.
   function automatic logic [63:0] stretch_key();
      logic [63:0] s;
      logic [7:0]  digit [8];
      int          nd;
      int          p;
      int          v;
      s = HASH_SEED;
      for (int r = 0; r < int'(round_count); r++) begin
         p = 0;
         for (int i = 0; i < pw_len; i++) begin
            s = absorb_byte(s, pw_bytes[i], p[1:0]);
            p++;
         end
         for (int i = 0; i < salt_len; i++) begin
            s = absorb_byte(s, salt_bytes[i], p[1:0]);
            p++;
         end
         v = r;
         nd = 0;
         do begin
            digit[nd] = DIGIT_ZERO + 8'(v % 10);
            v = v / 10;
            nd++;
         end while (v != 0);
         for (int i = nd - 1; i >= 0; i--) begin
            s = absorb_byte(s, digit[i], p[1:0]);
            p++;
         end
      end
      return s;
   endfunction

   always @(posedge clock) begin : track
      digest_type  want;
      logic [63:0] final_state;
      if (reset) begin
         pw_len = 0;
         salt_len = 0;
         dropped = 1'b0;
         round_count = ROUNDS_AT_RESET;
         digests_due.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == ROUND_COUNT_ADDR)
            round_count = pwdata[15:0];

         if (rsp_valid && rsp_ready) begin
            if (digests_due.size() == 0) begin
               $error("result beat arrived with no hash outstanding");
               mismatches++;
            end else begin
               want = digests_due.pop_front();
               checked++;
               if (rsp_masked_word !== want.masked_word) begin
                  $error("masked_word: expected %h, got %h", want.masked_word, rsp_masked_word);
                  mismatches++;
               end
               if (rsp_shifted_word !== want.shifted_word) begin
                  $error("shifted_word: expected %h, got %h", want.shifted_word,
                         rsp_shifted_word);
                  mismatches++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %b, got %b", want.overflow, rsp_overflow);
                  mismatches++;
               end
            end
         end

         if (req_valid && req_ready) begin
            unique case (req_opcode)
               OP_APPEND_PW: begin
                  if (pw_len < PASSWORD_DEPTH) begin
                     pw_bytes[pw_len] = req_data_byte;
                     pw_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               OP_APPEND_SALT: begin
                  if (salt_len < SALT_DEPTH) begin
                     salt_bytes[salt_len] = req_data_byte;
                     salt_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               OP_START: begin
                  final_state = stretch_key();
                  want.masked_word = final_state ^ OUT_XOR;
                  want.shifted_word = (final_state << 13) | (final_state >> 19);
                  want.overflow = dropped;
                  digests_due.push_back(want);
                  pw_len = 0;
                  salt_len = 0;
                  dropped = 1'b0;
               end
               default: ;
            endcase
         end
      end
      fail_count <= mismatches;
      hashes_waiting <= digests_due.size();
      hashes_checked <= checked;
   end

endmodule

FILE: bench/salted_iterated_password_hash_tb.sv
module salted_iterated_password_hash_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import siph_pkg::*;

   localparam logic [1:0] OP_UNUSED        = 2'd3;
   localparam logic [2:0] ROUND_COUNT_ADDR = {CSR_ROUND_COUNT, 2'b00};
   localparam int         PHASE_BEATS      = 300;
   localparam int         HOLD_CYCLES      = 5000;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   wire  [31:0] prdata;
   wire         pready;

   int fail_count;
   int hashes_waiting;
   int hashes_checked;
   int send_idle_pct;
   int recv_idle_pct;
   int beats_sent;
   int useful_beats;
   bit hold_request;

   siph_req_if req_if ();
   siph_rsp_if rsp_if ();

   salted_iterated_password_hash dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   key_stretch_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_opcode       (req_if.opcode),
      .req_data_byte    (req_if.data_byte),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_masked_word  (rsp_if.masked_word),
      .rsp_shifted_word (rsp_if.shifted_word),
      .rsp_overflow     (rsp_if.overflow),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .fail_count       (fail_count),
      .hashes_waiting   (hashes_waiting),
      .hashes_checked   (hashes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_beat(input logic [1:0] op, input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.opcode <= op;
      req_if.data_byte <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      beats_sent++;
      if (op != OP_UNUSED)
         useful_beats++;
   endtask

   // Drop valid, then hold until every hash has come back and the block is quiet.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (hashes_waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_rounds(input logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ROUND_COUNT_ADDR;
      pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // One password/salt load with random content, usually closed by a start.
   task automatic hash_sequence(input bit overfill);
      int pw_n;
      int salt_n;
      int pick;
      pick = $urandom_range(99);
      if (overfill || pick >= 94)
         pw_n = $urandom_range(134, 129);
      else if (pick < 5)
         pw_n = 0;
      else if (pick < 85)
         pw_n = $urandom_range(12, 1);
      else
         pw_n = $urandom_range(128, 13);
      pick = $urandom_range(99);
      if (overfill || pick >= 94)
         salt_n = $urandom_range(37, 33);
      else if (pick < 10)
         salt_n = 0;
      else if (pick < 85)
         salt_n = $urandom_range(8, 1);
      else
         salt_n = $urandom_range(32, 9);
      while (pw_n > 0 || salt_n > 0) begin
         if (salt_n == 0 || (pw_n > 0 && $urandom_range(1) == 0)) begin
            send_beat(OP_APPEND_PW, 8'($urandom_range(255)));
            pw_n--;
         end else begin
            send_beat(OP_APPEND_SALT, 8'($urandom_range(255)));
            salt_n--;
         end
         if ($urandom_range(99) < 4)
            send_beat(OP_UNUSED, 8'($urandom_range(255)));
      end
      // leave some loads open so their bytes carry into the next one
      if (overfill || $urandom_range(99) < 90)
         send_beat(OP_START, 8'($urandom_range(255)));
   endtask

   initial begin
      int phase_start;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.opcode <= OP_APPEND_PW;
      req_if.data_byte <= 8'd0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ROUND_COUNT_ADDR;
      pwdata <= 32'd0;
      send_idle_pct = 16;
      recv_idle_pct = 51;
      hold_request = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // round count left at its reset value
      send_beat(OP_APPEND_PW, 8'hFF);
      send_beat(OP_APPEND_SALT, 8'h00);
      send_beat(OP_START, 8'h00);
      drain();

      // zero rounds, empty and loaded stores, unused opcode
      write_rounds(16'd0);
      send_beat(OP_UNUSED, 8'hA5);
      send_beat(OP_START, 8'hFF);
      send_beat(OP_APPEND_PW, 8'h00);
      send_beat(OP_APPEND_PW, 8'h7F);
      send_beat(OP_APPEND_SALT, 8'hFF);
      send_beat(OP_APPEND_SALT, 8'h80);
      send_beat(OP_UNUSED, 8'h5A);
      send_beat(OP_START, 8'h00);
      drain();

      write_rounds(16'd1);
      send_beat(OP_APPEND_PW, 8'h55);
      send_beat(OP_APPEND_PW, 8'hAA);
      send_beat(OP_APPEND_SALT, 8'h01);
      send_beat(OP_START, 8'h00);
      drain();

      // three-digit round numbers
      write_rounds(16'd101);
      send_beat(OP_APPEND_PW, 8'h61);
      send_beat(OP_APPEND_PW, 8'h62);
      send_beat(OP_APPEND_SALT, 8'h78);
      send_beat(OP_START, 8'h00);
      drain();

      // largest round count, empty stores
      write_rounds(16'hFFFF);
      send_beat(OP_START, 8'h00);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         send_idle_pct = (phase < 2) ? 16 : (phase < 4) ? 51 : 0;
         recv_idle_pct = (phase < 2) ? 51 : (phase < 4) ? 16 : 0;
         write_rounds((phase == 3) ? 16'd11 : 16'($urandom_range(5, 1)));
         if (phase == 5) begin
            // stall the result side and keep offering work so the input backs up
            hold_request = 1'b1;
            repeat (4) begin
               repeat (3) send_beat(OP_APPEND_PW, 8'($urandom_range(255)));
               send_beat(OP_APPEND_SALT, 8'($urandom_range(255)));
               send_beat(OP_START, 8'($urandom_range(255)));
            end
            drain();
         end
         phase_start = useful_beats;
         if (phase == 0) begin
            hash_sequence(1'b1);
         end
         while (useful_beats - phase_start < PHASE_BEATS)
            hash_sequence(1'b0);
         drain();
      end

      repeat (16) @(posedge clock);
      $display("Sent %0d request beats and checked %0d hashes.", beats_sent, hashes_checked);
      $display("Rounds from 0 to 65535, overfilled stores and a long output stall.");
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/siph_pkg.sv
src/siph_req_if.sv
src/siph_rsp_if.sv
src/siph_ctrl.sv
src/siph_dp.sv
src/salted_iterated_password_hash.sv
bench/key_stretch_checker.sv
bench/salted_iterated_password_hash_tb.sv
